/* sv/sida_pkg.sv */
package sida_pkg;

  localparam int VALUE_W    = 32;
  localparam int VALUE_BITS = 32;
  localparam int CHAR_W     = 8;
  localparam int TOTAL_W    = 31;

  // decimal digits needed for an unsigned VALUE_BITS magnitude
  localparam int DIGITS      = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int BCD_W       = 4 * DIGITS;
  localparam int DIGIT_IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS + 1);

  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic             neg;
  } sida_conv_t;

endpackage

/* sv/sida_in_if.sv */
interface sida_in_if import sida_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

/* sv/sida_out_if.sv */
interface sida_out_if import sida_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  char_code;
  logic               is_last;
  logic [TOTAL_W-1:0] chars_total;

  modport source (output valid, output char_code, output is_last, output chars_total,
                  input ready);
  modport sink (input valid, input char_code, input is_last, input chars_total,
                output ready);
endinterface

/* sv/sida_dabble.sv */
module sida_dabble import sida_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sida_in_if.sink    number,
  output logic       conv_valid,
  input  logic       conv_ready,
  output sida_conv_t conv
);

  logic                  busy;
  logic                  done;
  logic [BIT_CNT_W-1:0]  cnt;
  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic                  neg;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] raw_mag;
  logic [BCD_W-1:0]      bcd_adj;

  assign raw     = number.value[VALUE_BITS-1:0];
  assign raw_mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  assign number.ready = !busy && !done;
  assign conv_valid   = done;
  assign conv.bcd     = bcd;
  assign conv.neg     = neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (number.valid && number.ready) begin
      busy <= 1'b1;
      cnt  <= BIT_CNT_W'(VALUE_BITS);
      mag  <= raw_mag;
      neg  <= raw[VALUE_BITS-1];
      bcd  <= '0;
    end else if (busy) begin
      bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == BIT_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (done && conv_ready) begin
      done <= 1'b0;
    end
  end

endmodule

/* sv/sida_emit.sv */
module sida_emit import sida_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       conv_valid,
  output logic       conv_ready,
  input  sida_conv_t conv,
  sida_out_if.source chars
);

  logic                   active;
  logic                   neg_pending;
  logic [BCD_W-1:0]       bcd;
  logic [DIGIT_IDX_W-1:0] idx;
  logic [TOTAL_W-1:0]     total;
  logic                   out_valid;
  logic [CHAR_W-1:0]      out_char;
  logic                   out_last;

  logic [DIGIT_IDX_W-1:0] lead;
  logic [3:0]             digit;
  logic                   slot_free;
  logic [TOTAL_W-1:0]     total_next;

  // highest nonzero digit, zero gives the units digit
  always_comb begin
    lead = '0;
    for (int d = 0; d < DIGITS; d++) begin
      if (conv.bcd[4*d +: 4] != 4'd0) begin
        lead = DIGIT_IDX_W'(d);
      end
    end
  end

  assign digit      = bcd[{idx, 2'b00} +: 4];
  assign slot_free  = !out_valid || chars.ready;
  assign total_next = (total == TOTAL_MAX) ? total : total + 1'b1;
  assign conv_ready = !active;

  assign chars.valid       = out_valid;
  assign chars.char_code   = out_char;
  assign chars.is_last     = out_last;
  assign chars.chars_total = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      neg_pending <= 1'b0;
      out_valid   <= 1'b0;
      total       <= '0;
    end else begin
      if (active && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && chars.ready) begin
        out_valid <= 1'b0;
      end
      if (!active) begin
        if (conv_valid) begin
          active      <= 1'b1;
          neg_pending <= conv.neg;
          bcd         <= conv.bcd;
          idx         <= lead;
        end
      end else if (slot_free) begin
        total <= total_next;
        if (neg_pending) begin
          out_char    <= CHAR_MINUS;
          out_last    <= 1'b0;
          neg_pending <= 1'b0;
        end else begin
          out_char <= CHAR_ZERO + {4'b0000, digit};
          out_last <= (idx == '0);
          if (idx == '0) begin
            active <= 1'b0;
          end else begin
            idx <= idx - 1'b1;
          end
        end
      end
    end
  end

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == CHAR_MINUS |-> !out_last)
    else $error("sign character marked last");

  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> total >= $past(total))
    else $error("character count went backward");

  a_sign_while_active: assert property (@(posedge clk) disable iff (rst)
    neg_pending |-> active)
    else $error("sign pending with no number loaded");

endmodule

/* sv/signed_int_to_decimal_ascii.sv */
// Prints a signed 32-bit integer as decimal ASCII, one character per output
// transfer, most significant first, with a leading '-' for negative values and
// is_last on the final digit; chars_total counts every character since reset and
// saturates. A number is converted by a shift-and-add-3 binary-to-BCD unit that
// takes one bit per cycle, then an emitter sends its characters one per cycle
// while the output is ready. The converter takes the next number while the
// emitter is still sending, so the sustained rate is bounded by the bit-serial
// conversion; the emitter also takes a load step for each number, so output
// stalls slow the rate only once they outlast the conversion.
module signed_int_to_decimal_ascii import sida_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sida_in_if.sink    number,
  sida_out_if.source chars
);

  logic       conv_valid;
  logic       conv_ready;
  sida_conv_t conv;

  sida_dabble u_dabble (
    .clk        (clk),
    .rst        (rst),
    .number     (number),
    .conv_valid (conv_valid),
    .conv_ready (conv_ready),
    .conv       (conv)
  );

  sida_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .conv_valid (conv_valid),
    .conv_ready (conv_ready),
    .conv       (conv),
    .chars      (chars)
  );

endmodule

/* sim/signed_int_to_decimal_ascii_tb.sv */
module signed_int_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sida_pkg::*;

  localparam int DIR_N       = 21;
  localparam int RAND_N      = 100;
  localparam int CALM_N      = 25;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 40;
  localparam int DRAIN_WAIT  = 100;
  localparam int STALL_LIMIT = 3000;

  typedef struct packed {
    logic [CHAR_W-1:0]  code;
    logic               last;
    logic [TOTAL_W-1:0] total;
  } char_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sida_in_if  number_if ();
  sida_out_if chars_if ();

  signed_int_to_decimal_ascii dut (
    .clk    (clk),
    .rst    (rst),
    .number (number_if),
    .chars  (chars_if)
  );

  always #5 clk = ~clk;

  char_exp_t          pending_chars[$];
  string              number_text[$];
  logic [TOTAL_W-1:0] char_count = '0;
  int                 mismatch_count = 0;
  int                 numbers_in = 0;
  int                 negatives_in = 0;
  int                 chars_checked = 0;
  bit                 calm = 1'b0;
  bit                 held = 1'b0;

  logic signed [VALUE_W-1:0] dir_value [DIR_N];
  string                     dir_text  [DIR_N];

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic string decimal_text(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    string              s;
    s   = "";
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    do begin
      s   = $sformatf("%c%s", CHAR_ZERO + (mag % 10), s);
      mag = mag / 10;
    end while (mag != 0);
    if (v[VALUE_W-1]) begin
      s = {"-", s};
    end
    return s;
  endfunction

  function automatic void queue_chars(input string text);
    char_exp_t e;
    for (int i = 0; i < text.len(); i++) begin
      if (char_count != TOTAL_MAX) begin
        char_count = char_count + 1'b1;
      end
      e.code  = text[i];
      e.last  = (i == text.len() - 1);
      e.total = char_count;
      pending_chars.push_back(e);
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_number();
    logic signed [VALUE_W-1:0] v;
    int unsigned               p;
    p = 1;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(0, 31);
      2: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        v = p + $urandom_range(0, 2) - 1;
      end
      3: v = $urandom_range(0, 20);
      default: begin
        repeat ($urandom_range(1, 8)) p = p * 10;
        v = p * $urandom_range(1, 2) + $urandom_range(0, 9) * (p / 1000) + $urandom_range(0, 9);
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic send_number(input logic signed [VALUE_W-1:0] v, input string text,
                             input bit idle_ok);
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      number_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    number_if.valid <= 1'b1;
    number_if.value <= v;
    number_text.push_back(text);
    do @(posedge clk); while (!number_if.ready);
  endtask

  // input and output transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (number_if.valid && number_if.ready) begin
        string t;
        t = number_text.pop_front();
        if (t == "") begin
          t = decimal_text(number_if.value);
        end
        queue_chars(t);
        numbers_in++;
        if (number_if.value[VALUE_W-1]) begin
          negatives_in++;
        end
      end
      if (chars_if.valid && chars_if.ready) begin
        char_exp_t e;
        chars_checked++;
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("char %0d with nothing pending", chars_if.char_code));
        end else begin
          e = pending_chars.pop_front();
          if (chars_if.char_code !== e.code) begin
            report_mismatch($sformatf("char_code got %0d want %0d", chars_if.char_code, e.code));
          end
          if (chars_if.is_last !== e.last) begin
            report_mismatch($sformatf("is_last got %0b want %0b", chars_if.is_last, e.last));
          end
          if (chars_if.chars_total !== e.total) begin
            report_mismatch($sformatf("chars_total got %0d want %0d",
                                      chars_if.chars_total, e.total));
          end
        end
      end
    end
  end

  // receiver
  initial begin
    chars_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && !held && numbers_in >= HOLD_AFTER) begin
        held = 1'b1;
        chars_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!rst && !calm && $urandom_range(0, 5) == 0) begin
        chars_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      chars_if.ready <= 1'b1;
    end
  end

  // watchdog
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (number_if.valid && number_if.ready) || (chars_if.valid && chars_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // sender and end of run
  initial begin
    dir_value = '{32'sd0, 32'sd2147483647, 32'sh80000000, -32'sd1, 32'sd1, -32'sd2147483647,
                  32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100000, 32'sd1000000000,
                  -32'sd1000000000, 32'sd1000000001, 32'sd999999999, 32'sd2147483646,
                  32'sd0, 32'sd1000200030, -32'sd900000009, 32'sh55555555, 32'shaaaaaaaa};
    dir_text  = '{"0", "2147483647", "-2147483648", "-1", "1", "-2147483647",
                  "", "", "", "", "", "", "", "", "", "", "0", "", "", "", ""};
    number_if.valid <= 1'b0;
    number_if.value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DIR_N; i++) begin
      send_number(dir_value[i], dir_text[i], 1'b1);
    end
    for (int i = 0; i < RAND_N; i++) begin
      if (i >= RAND_N - CALM_N) begin
        calm = 1'b1;
      end
      send_number(random_number(), "", !calm);
    end
    number_if.valid <= 1'b0;
    while (pending_chars.size() != 0 || number_text.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("run covered %0d numbers (%0d negative) and %0d characters,",
             numbers_in, negatives_in, chars_checked);
    $display("with random stalls on both sides and one long output hold-off");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* signed_int_to_decimal_ascii.f */
sv/sida_pkg.sv
sv/sida_in_if.sv
sv/sida_out_if.sv
sv/sida_dabble.sv
sv/sida_emit.sv
sv/signed_int_to_decimal_ascii.sv
sim/signed_int_to_decimal_ascii_tb.sv
